### hw/rtl/jacobi_linear_solver_defines.svh
// ----------------------------------------------------------------------------
// Jacobi solver assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef JACOBI_LINEAR_SOLVER_DEFINES_SVH
`define JACOBI_LINEAR_SOLVER_DEFINES_SVH

// same-cycle implication
`define JLS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define JLS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/jls_pkg.sv
// ----------------------------------------------------------------------------
// Jacobi solver package
// Request opcodes, status codes, register indexes and divider widths.
// ----------------------------------------------------------------------------
`default_nettype none

package jls_pkg;

	typedef enum logic [1:0] {
		OP_LOAD_MAT = 2'd0,
		OP_LOAD_RHS = 2'd1,
		OP_SOLVE    = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		STAT_CONVERGED = 2'd0,
		STAT_LIMIT     = 2'd1,
		STAT_ZERO_DIAG = 2'd2
	} solve_status_t;

	typedef enum logic [1:0] {
		REG_SIZE     = 2'd0,
		REG_TOL      = 2'd1,
		REG_MAX_ITER = 2'd2
	} reg_index_t;

	localparam int unsigned QUOT_W = 64;
	localparam int unsigned DEN_W  = 32;

endpackage

`default_nettype wire

### hw/rtl/jls_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module jls_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### hw/rtl/jls_div.sv
// ----------------------------------------------------------------------------
// Unsigned divider
// Restoring shift-subtract divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module jls_div
	import jls_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [QUOT_W-1:0] num_mag,
	input  wire logic [DEN_W-1:0]  den_mag,
	output logic                   done,
	output logic      [QUOT_W-1:0] quot
);

	localparam int unsigned CW = $clog2(QUOT_W);

	logic              busy_q;
	logic [CW-1:0]     cnt_q;
	logic [DEN_W-1:0]  den_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W:0]    rem_sh;
	logic              take;

	assign rem_sh = {rem_q, quot[QUOT_W-1]};
	assign take   = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(QUOT_W - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot  <= num_mag;
			den_q <= den_mag;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= take ? DEN_W'(rem_sh - {1'b0, den_q}) : DEN_W'(rem_sh);
			quot  <= {quot[QUOT_W-2:0], take};
		end
	end

endmodule

`default_nettype wire

### hw/rtl/jacobi_linear_solver.sv
// ----------------------------------------------------------------------------
// Jacobi linear solver
// Fixed-point Q16.16 Jacobi iteration over a matrix held in on-chip RAM.
// ----------------------------------------------------------------------------
// Load requests (matrix entry, right-hand-side entry) are taken one per
// cycle while the solver is idle. A solve request copies b into x, then
// runs sweeps. Each row of a sweep reads the matrix and x through the
// single read port of each RAM, drains the multiply-accumulate pipeline,
// starts the divider, waits for the shift-subtract division by the
// diagonal to finish, then writes back and updates the error. Each sweep
// ends with a closing step. A solve then emits n results (n = size in use),
// one at a time, holding while the output is stalled. No request is
// taken while a solve runs.
`default_nettype none
`include "jacobi_linear_solver_defines.svh"

module jacobi_linear_solver
	import jls_pkg::*;
#(
	parameter int unsigned MAX_UNKNOWNS  = 16,
	parameter int unsigned FRACTION_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [3:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready,
	input  wire logic               valid_in,
	output logic                    ready_in,
	input  wire logic [1:0]         opcode,
	input  wire logic [3:0]         row_index,
	input  wire logic [3:0]         column_index,
	input  wire logic signed [31:0] data_value,
	output logic                    valid,
	input  wire logic               ready,
	output logic      [3:0]         solution_index,
	output logic signed [31:0]      solution_value,
	output logic      [15:0]        sweeps_done,
	output logic      [1:0]         solve_status,
	output logic                    last_component
);

	localparam int unsigned IW  = $clog2(MAX_UNKNOWNS);
	localparam int unsigned MD  = MAX_UNKNOWNS * MAX_UNKNOWNS;
	localparam int unsigned MAW = $clog2(MD);
	localparam int unsigned XAW = IW + 1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_INIT, ST_INIT_END, ST_ROW, ST_DRAIN, ST_DIVST, ST_DIVW,
		ST_FIN, ST_ERR, ST_SWEND, ST_EMIT_RD, ST_EMIT_LD
	} state_t;

	function automatic logic [MAW-1:0] mat_addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
		mat_addr = MAW'(MAW'(r) * MAW'(MAX_UNKNOWNS) + MAW'(c));
	endfunction

	state_t               state_q;
	logic [4:0]           size_q;
	logic [30:0]          tol_q;
	logic [15:0]          maxit_q;
	logic [61:0]          tolsq_q;
	logic [IW-1:0]        lidx_q, iss_q, row_q, j_s1;
	logic                 v_s1, init_s1, pv_s2, zdiag_q, bank_q, neg_q;
	logic signed [63:0]   prod_s2, acc_q;
	logic signed [31:0]   b_q, diag_q, xold_q, nxt_q;
	logic [63:0]          sq_q, err_q;
	logic [15:0]          sweep_q;
	logic                 out_valid_q, out_last_q;
	logic [3:0]           out_idx_q;
	logic signed [31:0]   out_val_q;
	logic [15:0]          out_sweeps_q;
	solve_status_t        out_status_q, status_q;

	logic                 cfg_wr, in_acc, row_ok, col_ok;
	logic                 mat_we, rhs_we, x_we;
	logic [MAW-1:0]       mat_waddr, mat_raddr;
	logic [IW-1:0]        ld_row, ld_col, rhs_raddr;
	logic [XAW-1:0]       x_waddr;
	logic [31:0]          x_wdata;
	logic signed [31:0]   mat_rd, rhs_rd, x_rd;
	logic signed [64:0]   acc_sum;
	logic signed [65:0]   num_full;
	logic signed [63:0]   num_sat;
	logic [63:0]          num_mag, quot;
	logic [31:0]          den_mag;
	logic                 div_start, div_done;
	logic signed [32:0]   dx;
	logic [31:0]          dx_mag;
	logic [64:0]          err_sum;
	logic                 zd_now, run_ok, above;
	logic signed [31:0]   q_sat;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite;
	assign ready_in = state_q == ST_IDLE;
	assign in_acc   = valid_in && ready_in;
	assign row_ok   = 32'(row_index) < MAX_UNKNOWNS;
	assign col_ok   = 32'(column_index) < MAX_UNKNOWNS;
	assign ld_row   = IW'(row_index);
	assign ld_col   = IW'(column_index);

	always_comb begin
		case (reg_index_t'(paddr[3:2]))
			REG_SIZE:     prdata = {27'd0, size_q};
			REG_TOL:      prdata = {1'b0, tol_q};
			REG_MAX_ITER: prdata = {16'd0, maxit_q};
			default:      prdata = '0;
		endcase
	end

	assign mat_we    = in_acc && opcode == OP_LOAD_MAT && row_ok && col_ok;
	assign mat_waddr = mat_addr(ld_row, ld_col);
	assign mat_raddr = (state_q == ST_INIT) ? mat_addr(iss_q, iss_q) : mat_addr(row_q, iss_q);
	assign rhs_we    = in_acc && opcode == OP_LOAD_RHS && row_ok;
	assign rhs_raddr = (state_q == ST_INIT) ? iss_q : row_q;
	assign x_we      = (v_s1 && init_s1) || state_q == ST_FIN;
	assign x_waddr   = (v_s1 && init_s1) ? {1'b0, j_s1} : {~bank_q, row_q};
	assign x_wdata   = (v_s1 && init_s1) ? rhs_rd : nxt_q;

	jls_ram #(.WIDTH(32), .DEPTH(MD)) u_mat (
		.clk(clk), .we(mat_we), .waddr(mat_waddr), .wdata(data_value),
		.raddr(mat_raddr), .rdata(mat_rd)
	);

	jls_ram #(.WIDTH(32), .DEPTH(MAX_UNKNOWNS)) u_rhs (
		.clk(clk), .we(rhs_we), .waddr(ld_row), .wdata(data_value),
		.raddr(rhs_raddr), .rdata(rhs_rd)
	);

	jls_ram #(.WIDTH(32), .DEPTH(2 * MAX_UNKNOWNS)) u_x (
		.clk(clk), .we(x_we), .waddr(x_waddr), .wdata(x_wdata),
		.raddr({bank_q, iss_q}), .rdata(x_rd)
	);

	assign acc_sum  = 65'(acc_q) + 65'(prod_s2);
	assign num_full = (66'(b_q) <<< FRACTION_BITS) - 66'(acc_q);
	always_comb begin
		if (num_full > 66'sh0_7FFF_FFFF_FFFF_FFFF) begin
			num_sat = 64'sh7FFF_FFFF_FFFF_FFFF;
		end else if (num_full < -66'sh0_8000_0000_0000_0000) begin
			num_sat = 64'sh8000_0000_0000_0000;
		end else begin
			num_sat = 64'(num_full);
		end
	end
	assign num_mag   = num_sat[63] ? 64'(-num_sat) : 64'(num_sat);
	assign den_mag   = diag_q[31] ? 32'(-diag_q) : 32'(diag_q);
	assign div_start = state_q == ST_DIVST;

	jls_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num_mag(num_mag),
		.den_mag(den_mag), .done(div_done), .quot(quot)
	);

	always_comb begin
		if (neg_q) begin
			q_sat = (quot > 64'h8000_0000) ? 32'sh8000_0000 : 32'(-quot);
		end else begin
			q_sat = (quot > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(quot);
		end
	end

	assign dx      = 33'(nxt_q) - 33'(xold_q);
	assign dx_mag  = dx[32] ? 32'(-dx) : 32'(dx);
	assign err_sum = 65'(err_q) + 65'(sq_q);
	assign zd_now  = zdiag_q || mat_rd == '0;
	assign run_ok  = tol_q != '0 && maxit_q != '0;
	assign above   = err_q > {2'b0, tolsq_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q  <= 5'd16;
			tol_q   <= 31'd66;
			maxit_q <= 16'd1000;
		end else if (cfg_wr) begin
			case (reg_index_t'(paddr[3:2]))
				REG_SIZE:     size_q  <= pwdata[4:0];
				REG_TOL:      tol_q   <= pwdata[30:0];
				REG_MAX_ITER: maxit_q <= pwdata[15:0];
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= mat_rd * x_rd;
		sq_q    <= 64'(dx_mag) * 64'(dx_mag);
		if (v_s1 && !init_s1) begin
			b_q <= rhs_rd;
			if (j_s1 == row_q) begin
				diag_q <= mat_rd;
				xold_q <= x_rd;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			v_s1        <= 1'b0;
			init_s1     <= 1'b0;
			pv_s2       <= 1'b0;
			j_s1        <= '0;
			iss_q       <= '0;
			row_q       <= '0;
			lidx_q      <= '0;
			zdiag_q     <= 1'b0;
			bank_q      <= 1'b0;
			neg_q       <= 1'b0;
			acc_q       <= '0;
			err_q       <= '0;
			nxt_q       <= '0;
			tolsq_q     <= '0;
			sweep_q     <= '0;
			status_q    <= STAT_CONVERGED;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
			out_idx_q   <= '0;
			out_val_q   <= '0;
			out_sweeps_q <= '0;
			out_status_q <= STAT_CONVERGED;
		end else begin
			v_s1    <= state_q == ST_INIT || state_q == ST_ROW;
			init_s1 <= state_q == ST_INIT;
			pv_s2   <= v_s1 && !init_s1 && j_s1 != row_q;
			j_s1    <= iss_q;
			if (pv_s2) begin
				if (acc_sum[64] != acc_sum[63]) begin
					acc_q <= acc_sum[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
				end else begin
					acc_q <= 64'(acc_sum);
				end
			end
			if (v_s1 && init_s1 && mat_rd == '0) begin
				zdiag_q <= 1'b1;
			end
			if (out_valid_q && ready && state_q != ST_EMIT_LD) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc && opcode == OP_SOLVE) begin
						if (size_q == '0) begin
							lidx_q <= '0;
						end else if (32'(size_q) > MAX_UNKNOWNS) begin
							lidx_q <= IW'(MAX_UNKNOWNS - 1);
						end else begin
							lidx_q <= IW'(size_q - 5'd1);
						end
						tolsq_q <= 62'(tol_q) * 62'(tol_q);
						iss_q   <= '0;
						zdiag_q <= 1'b0;
						bank_q  <= 1'b0;
						sweep_q <= '0;
						state_q <= ST_INIT;
					end
				end
				ST_INIT: begin
					if (iss_q == lidx_q) begin
						state_q <= ST_INIT_END;
					end else begin
						iss_q <= iss_q + 1'b1;
					end
				end
				ST_INIT_END: begin
					iss_q <= '0;
					row_q <= '0;
					acc_q <= '0;
					err_q <= '0;
					if (run_ok && zd_now) begin
						status_q <= STAT_ZERO_DIAG;
						state_q  <= ST_EMIT_RD;
					end else if (run_ok) begin
						state_q <= ST_ROW;
					end else begin
						status_q <= (tol_q != '0) ? STAT_LIMIT : STAT_CONVERGED;
						state_q  <= ST_EMIT_RD;
					end
				end
				ST_ROW: begin
					if (iss_q == lidx_q) begin
						iss_q   <= '0;
						state_q <= ST_DRAIN;
					end else begin
						iss_q <= iss_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (!v_s1 && !pv_s2) begin
						state_q <= ST_DIVST;
					end
				end
				ST_DIVST: begin
					neg_q   <= num_sat[63] != diag_q[31];
					state_q <= ST_DIVW;
				end
				ST_DIVW: begin
					if (div_done) begin
						nxt_q   <= q_sat;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					state_q <= ST_ERR;
				end
				ST_ERR: begin
					err_q <= err_sum[64] ? '1 : 64'(err_sum);
					acc_q <= '0;
					if (row_q == lidx_q) begin
						state_q <= ST_SWEND;
					end else begin
						row_q   <= row_q + 1'b1;
						state_q <= ST_ROW;
					end
				end
				ST_SWEND: begin
					bank_q  <= ~bank_q;
					sweep_q <= sweep_q + 16'd1;
					row_q   <= '0;
					err_q   <= '0;
					if (17'(sweep_q) + 17'd1 < 17'(maxit_q) && above) begin
						state_q <= ST_ROW;
					end else begin
						status_q <= above ? STAT_LIMIT : STAT_CONVERGED;
						state_q  <= ST_EMIT_RD;
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_LD;
				end
				ST_EMIT_LD: begin
					if (!out_valid_q || ready) begin
						out_valid_q  <= 1'b1;
						out_idx_q    <= 4'(iss_q);
						out_val_q    <= x_rd;
						out_sweeps_q <= sweep_q;
						out_status_q <= status_q;
						out_last_q   <= iss_q == lidx_q;
						if (iss_q == lidx_q) begin
							iss_q   <= '0;
							state_q <= ST_IDLE;
						end else begin
							iss_q   <= iss_q + 1'b1;
							state_q <= ST_EMIT_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign valid          = out_valid_q;
	assign solution_index = out_idx_q;
	assign solution_value = out_val_q;
	assign sweeps_done    = out_sweeps_q;
	assign solve_status   = out_status_q;
	assign last_component = out_last_q;

	`JLS_ASSERT_IMPL(a_div_done_in_wait, div_done, state_q == ST_DIVW, "divider done outside wait")
	`JLS_ASSERT_NEXT(a_sweep_count, state_q == ST_SWEND, sweep_q == $past(sweep_q) + 16'd1, "sweep count")
	`JLS_ASSERT_IMPL(a_zero_diag_no_sweep, out_valid_q && out_status_q == STAT_ZERO_DIAG, out_sweeps_q == '0, "zero diagonal with sweeps")

endmodule

`default_nettype wire

### tb/jacobi_linear_solver_tb.sv
// ----------------------------------------------------------------------------
// Jacobi linear solver testbench
// Loads small linear systems, sets size, tolerance and sweep limit over the
// configuration port, issues solve requests and checks every emitted
// solution component against a fixed-point Jacobi predictor run when each solve is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module jacobi_linear_solver_tb;
	import jls_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          NUM_UNK   = 16;
	localparam int          FRAC      = 16;
	localparam int          ITEM_GOAL = 310;
	localparam logic [1:0]  OP_UNUSED = 2'd3;
	localparam longint      S64_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint      S64_MIN   = 64'sh8000_0000_0000_0000;
	localparam logic [63:0] U64_MAX   = '1;

	typedef struct {
		logic [1:0]         op;
		logic [3:0]         row;
		logic [3:0]         col;
		logic signed [31:0] data;
	} request_t;

	typedef struct {
		logic [3:0]         idx;
		logic signed [31:0] value;
		logic [15:0]        sweeps;
		logic [1:0]         status;
		logic               last;
	} component_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [3:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               valid_in = 1'b0;
	logic               ready_in;
	logic [1:0]         opcode = '0;
	logic [3:0]         row_index = '0;
	logic [3:0]         column_index = '0;
	logic signed [31:0] data_value = '0;
	logic               valid;
	logic               ready = 1'b0;
	logic [3:0]         solution_index;
	logic signed [31:0] solution_value;
	logic [15:0]        sweeps_done;
	logic [1:0]         solve_status;
	logic               last_component;

	jacobi_linear_solver u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.valid_in(valid_in), .ready_in(ready_in), .opcode(opcode),
		.row_index(row_index), .column_index(column_index), .data_value(data_value),
		.valid(valid), .ready(ready), .solution_index(solution_index),
		.solution_value(solution_value), .sweeps_done(sweeps_done),
		.solve_status(solve_status), .last_component(last_component)
	);

	always #10 clk = ~clk;

	// solver image
	logic signed [31:0] a_mat [NUM_UNK][NUM_UNK];
	logic signed [31:0] b_vec [NUM_UNK];
	logic [4:0]         size_reg = 5'd16;
	logic [30:0]        tol_reg = 31'd66;
	logic [15:0]        iter_reg = 16'd1000;

	request_t   pending_reqs[$];
	component_t solution_q[$];
	request_t   cur_req;
	int         reqs_sent = 0;
	int         reqs_taken = 0;
	int         errors = 0;
	int         cyc = 0;
	bit         req_taken = 1'b0;
	bit         hold_arm = 1'b0;
	bit         hold_done = 1'b0;
	int         hold_left = 0;
	bit         quiet;

	assign quiet = (cyc > 3000) && (cyc < 9000);

	function automatic longint sat_sum(longint a, longint b);
		if (b > 0 && a > S64_MAX - b) return S64_MAX;
		if (b < 0 && a < S64_MIN - b) return S64_MIN;
		return a + b;
	endfunction

	function automatic logic signed [31:0] sat_quot(longint num, logic signed [31:0] den);
		logic [63:0] mn, md, q;
		bit          neg;
		mn  = num < 0 ? 64'd0 - 64'(num) : 64'(num);
		md  = den < 0 ? 64'd0 - 64'(longint'(den)) : 64'(longint'(den));
		neg = (num < 0) != (den < 0);
		q   = mn / md;
		if (neg) begin
			if (q > 64'h8000_0000) return 32'sh8000_0000;
			return 32'(-longint'(q));
		end
		if (q > 64'h7FFF_FFFF) return 32'sh7FFF_FFFF;
		return 32'(q);
	endfunction

	function automatic void predict_solve();
		int                 n;
		logic signed [31:0] x [NUM_UNK];
		logic signed [31:0] xn [NUM_UNK];
		logic [63:0]        tol_sq, err, mag, sq;
		longint             acc, num, d;
		bit                 above;
		logic [15:0]        sweeps;
		solve_status_t      status;
		component_t         c;
		n = size_reg;
		if (n < 1) n = 1;
		if (n > NUM_UNK) n = NUM_UNK;
		tol_sq = 64'(tol_reg) * 64'(tol_reg);
		above  = tol_reg != 0;
		sweeps = 0;
		status = STAT_CONVERGED;
		for (int i = 0; i < n; i++) x[i] = b_vec[i];
		if (above && iter_reg > 0)
			for (int i = 0; i < n; i++)
				if (a_mat[i][i] == 0) status = STAT_ZERO_DIAG;
		if (status != STAT_ZERO_DIAG) begin
			while (sweeps < iter_reg && above) begin
				err = 0;
				for (int i = 0; i < n; i++) begin
					acc = 0;
					for (int j = 0; j < n; j++)
						if (j != i)
							acc = sat_sum(acc, longint'(a_mat[i][j]) * longint'(x[j]));
					num = longint'(b_vec[i]) * (longint'(1) << FRAC);
					if (acc == S64_MIN) num = sat_sum(sat_sum(num, S64_MAX), 1);
					else num = sat_sum(num, -acc);
					xn[i] = sat_quot(num, a_mat[i][i]);
					d   = longint'(xn[i]) - longint'(x[i]);
					mag = d < 0 ? 64'(-d) : 64'(d);
					sq  = mag * mag;
					err = (err > U64_MAX - sq) ? U64_MAX : err + sq;
				end
				for (int i = 0; i < n; i++) x[i] = xn[i];
				above = err > tol_sq;
				sweeps++;
			end
			status = above ? STAT_LIMIT : STAT_CONVERGED;
		end
		for (int i = 0; i < n; i++) begin
			c.idx = 4'(i); c.value = x[i]; c.sweeps = sweeps;
			c.status = status; c.last = (i == n - 1);
			solution_q.push_back(c);
		end
	endfunction

	// request side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_taken <= 1'b0;
		end else begin
			req_taken <= valid_in && ready_in;
			cyc <= cyc + 1;
			if (valid_in && ready_in) begin
				reqs_taken <= reqs_taken + 1;
				case (opcode)
					OP_LOAD_MAT: a_mat[row_index][column_index] = data_value;
					OP_LOAD_RHS: b_vec[row_index] = data_value;
					OP_SOLVE:    predict_solve();
					default: ;
				endcase
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!valid_in || req_taken)) begin
			if (pending_reqs.size() > 0 && (quiet || $urandom_range(99) >= 9)) begin
				cur_req = pending_reqs.pop_front();
				opcode       <= cur_req.op;
				row_index    <= cur_req.row;
				column_index <= cur_req.col;
				data_value   <= cur_req.data;
				valid_in     <= 1'b1;
			end else begin
				valid_in <= 1'b0;
			end
		end
	end

	// result side
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_arm && !hold_done && valid) begin
				hold_done = 1'b1;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left = hold_left - 1;
				ready <= 1'b0;
			end else begin
				ready <= quiet || $urandom_range(99) >= 9;
			end
		end
	end

	always @(posedge clk) begin
		component_t e;
		if (arst_n && valid && ready) begin
			if (solution_q.size() == 0) begin
				$display("%t: unexpected result idx=%0d value=%0d", $realtime,
					solution_index, solution_value);
				errors++;
			end else begin
				e = solution_q.pop_front();
				if (solution_index !== e.idx) begin
					$display("%t: solution_index exp %0d got %0d", $realtime,
						e.idx, solution_index);
					errors++;
				end
				if (solution_value !== e.value) begin
					$display("%t: solution_value[%0d] exp %0d got %0d", $realtime,
						e.idx, e.value, solution_value);
					errors++;
				end
				if (sweeps_done !== e.sweeps) begin
					$display("%t: sweeps_done exp %0d got %0d", $realtime,
						e.sweeps, sweeps_done);
					errors++;
				end
				if (solve_status !== e.status) begin
					$display("%t: solve_status exp %0d got %0d", $realtime,
						e.status, solve_status);
					errors++;
				end
				if (last_component !== e.last) begin
					$display("%t: last_component exp %0d got %0d", $realtime,
						e.last, last_component);
					errors++;
				end
			end
		end
	end

	task automatic put_req(logic [1:0] op, int row, int col, logic [31:0] data);
		request_t r;
		r.op = op; r.row = 4'(row); r.col = 4'(col); r.data = data;
		pending_reqs.push_back(r);
		reqs_sent++;
	endtask

	task automatic settle();
		while (reqs_taken != reqs_sent || solution_q.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(reg_index_t r, logic [31:0] v);
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= {r, 2'b00}; pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (r)
			REG_SIZE:     size_reg = v[4:0];
			REG_TOL:      tol_reg = v[30:0];
			REG_MAX_ITER: iter_reg = v[15:0];
			default: ;
		endcase
	endtask

	task automatic configure(int sz, logic [31:0] tol, int iters);
		settle();
		write_reg(REG_SIZE, 32'(sz));
		write_reg(REG_TOL, tol);
		write_reg(REG_MAX_ITER, 32'(iters));
	endtask

	function automatic logic [31:0] rand_diag();
		logic [31:0] m;
		m = {12'd0, 4'($urandom_range(3, 9)), 16'($urandom)};
		return $urandom_range(1) ? -m : m;
	endfunction

	task automatic load_system(int n, bit dominant);
		for (int i = 0; i < n; i++)
			for (int j = 0; j < n; j++)
				if (!dominant)
					put_req(OP_LOAD_MAT, i, j, $urandom);
				else if (i == j)
					put_req(OP_LOAD_MAT, i, j, rand_diag());
				else
					put_req(OP_LOAD_MAT, i, j, 32'($signed(17'($urandom))) >>> 1);
		for (int i = 0; i < n; i++)
			put_req(OP_LOAD_RHS, i, $urandom_range(15),
				dominant ? 32'($signed(20'($urandom))) : 32'($urandom));
	endtask

	task automatic add_noise(int k);
		for (int q = 0; q < k; q++)
			case ($urandom_range(2))
				0: put_req(OP_UNUSED, $urandom_range(15), $urandom_range(15), $urandom);
				1: put_req(OP_LOAD_MAT, $urandom_range(15), $urandom_range(15), $urandom);
				default: put_req(OP_LOAD_RHS, $urandom_range(15), $urandom_range(15),
					$urandom);
			endcase
	endtask

	initial begin
		int          n, sz, iters, phase;
		logic [31:0] tol;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// single unknown, extreme entries, long sweep limit
		configure(1, 32'd66, 65535);
		put_req(OP_LOAD_MAT, 0, 0, 32'h8000_0000);
		put_req(OP_LOAD_RHS, 0, 15, 32'h7FFF_FFFF);
		put_req(OP_SOLVE, 0, 0, 32'd0);
		// zero diagonal; far corner and unused opcode as noise
		configure(2, 32'd66, 5);
		put_req(OP_LOAD_MAT, 0, 0, 32'd0);
		put_req(OP_LOAD_MAT, 0, 1, 32'h0001_0000);
		put_req(OP_LOAD_MAT, 1, 0, 32'h0001_0000);
		put_req(OP_LOAD_MAT, 1, 1, 32'h0004_0000);
		put_req(OP_LOAD_RHS, 1, 0, 32'hFFFF_0000);
		put_req(OP_LOAD_MAT, 15, 15, 32'h7FFF_FFFF);
		put_req(OP_LOAD_RHS, 15, 15, 32'h8000_0000);
		put_req(OP_UNUSED, 15, 15, 32'hFFFF_FFFF);
		put_req(OP_SOLVE, 15, 15, 32'hFFFF_FFFF);
		// zero tolerance, size zero acts as one
		configure(0, 32'd0, 10);
		put_req(OP_SOLVE, 0, 0, 32'd0);
		// zero sweep limit
		configure(2, 32'd5, 0);
		put_req(OP_SOLVE, 0, 0, 32'd0);
		// largest tolerance
		configure(2, 32'h7FFF_FFFF, 3);
		put_req(OP_LOAD_MAT, 0, 0, 32'h0003_0000);
		put_req(OP_SOLVE, 0, 0, 32'd0);

		phase = 0;
		while (reqs_sent < ITEM_GOAL) begin
			case ($urandom_range(11))
				0:       sz = 16;
				1:       sz = $urandom_range(1) ? 0 : $urandom_range(17, 31);
				default: sz = $urandom_range(1, 5);
			endcase
			n = (sz < 1) ? 1 : (sz > 16 ? 16 : sz);
			// keep the request count near the goal
			if (reqs_sent + (phase == 3 ? 2 : 1) * (n * n + n) > ITEM_GOAL + 60) begin
				sz = $urandom_range(1, 5);
				n  = sz;
			end
			case ($urandom_range(7))
				0:       tol = 0;
				1:       tol = 32'h7FFF_FFFF;
				2:       tol = $urandom & 32'h7FFF_FFFF;
				default: tol = $urandom_range(1, 400);
			endcase
			iters = (n > 8) ? $urandom_range(0, 2) : $urandom_range(0, 12);
			configure(sz, tol, iters);
			load_system(n, $urandom_range(4) != 0);
			if ($urandom_range(4) == 0) add_noise($urandom_range(1, 4));
			put_req(OP_SOLVE, $urandom_range(15), $urandom_range(15), $urandom);
			if (phase == 3) begin
				// stall results while the next system queues up behind the solve
				hold_arm = 1'b1;
				load_system(n, 1'b1);
				put_req(OP_SOLVE, 0, 0, 32'd0);
			end
			phase++;
		end

		settle();
		repeat (50) @(negedge clk);
		if (errors == 0)
			$display("jacobi_linear_solver regression: pass");
		else
			$display("jacobi_linear_solver regression: fail");
		$finish;
	end

	initial begin
		#(20ns * 3_000_000);
		$display("jacobi_linear_solver regression: fail");
		$finish;
	end

endmodule

`default_nettype wire

### jacobi_linear_solver.f
+incdir+hw/rtl
hw/rtl/jls_pkg.sv
hw/rtl/jls_ram.sv
hw/rtl/jls_div.sv
hw/rtl/jacobi_linear_solver.sv
tb/jacobi_linear_solver_tb.sv
